// ===== rtl/core/mqef_pkg.sv =====
// Shared types and constants for the multi-queue event FIFO core.
package mqef_pkg;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int STACK_DEPTH_DEF = 4;

    localparam logic [1:0] REG_QUEUE_SIZE    = 2'd0;
    localparam logic [1:0] REG_PUSH_SIZE     = 2'd1;
    localparam logic [1:0] REG_COLUMN_ENABLE = 2'd2;

    localparam logic [2:0] OP_ENQ       = 3'd0;
    localparam logic [2:0] OP_GATED_ENQ = 3'd1;
    localparam logic [2:0] OP_DEQ       = 3'd2;
    localparam logic [2:0] OP_PEEK      = 3'd3;
    localparam logic [2:0] OP_PUSH      = 3'd4;
    localparam logic [2:0] OP_DUMP      = 3'd5;
    localparam logic [2:0] OP_RST_Q     = 3'd6;
    localparam logic [2:0] OP_RST_ALL   = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_STK_FULL = 3'd3;
    localparam logic [2:0] ST_DROPPED  = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  queue_sel;
        logic [31:0] event_in;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] event_out;
        logic [4:0]  count;
        logic        empty_flag;
        logic        full_flag;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_item_t;

endpackage

// ===== rtl/core/multi_queue_event_fifo_core.sv =====
// Multi-queue event FIFO core: top level with control sequencer and queue state.
// Every operation passes through the execute and done states; a dump also runs
// one stack read then one queue write per stacked entry.
// A new operation is accepted only in the idle state, after the last one is through; a waiting result
// does not block the next input, but the sequencer holds in its last state until it drains.
// Reset clears all queue indices, counts and stack counts and restores the configuration
// defaults; the event and stack memories are not cleared and have no clearing pass.
module multi_queue_event_fifo_core #(
    parameter int NUM_QUEUES  = mqef_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqef_pkg::QUEUE_DEPTH_DEF,
    parameter int STACK_DEPTH = mqef_pkg::STACK_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mqef_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mqef_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  mqef_pkg::cfg_item_t  cfg_data
);
    import mqef_pkg::*;

    localparam int QW  = $clog2(NUM_QUEUES);
    localparam int HW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PW  = $clog2(STACK_DEPTH + 1);
    localparam int QAW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int SAW = $clog2(NUM_QUEUES * STACK_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DUMP_RD, S_DUMP_WR, S_DONE} state_t;

    state_t      state_reg;
    in_item_t    op_reg;
    logic [QW-1:0] q_reg;
    logic        qvalid_reg;
    logic [4:0]  qsize_reg;
    logic [2:0]  psize_reg;
    logic [6:0]  colen_reg;
    logic [HW-1:0] head_reg [NUM_QUEUES];
    logic [HW-1:0] tail_reg [NUM_QUEUES];
    logic [CW-1:0] cnt_reg  [NUM_QUEUES];
    logic [PW-1:0] scnt_reg [NUM_QUEUES];
    logic [PW-1:0] di_reg;
    logic [2:0]  st_reg;
    logic [31:0] evo_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic [CW-1:0] sz;
    logic [PW-1:0] psz;
    logic          col_act;
    logic [31:0]   qrd, srd;
    logic          qwe, swe;
    logic [QAW-1:0] qwa, qra;
    logic [SAW-1:0] swa, sra;
    logic [31:0]   qwd;

    always_comb
    begin
        if (qsize_reg == 5'd0)
            sz = CW'(1);
        else if (32'(qsize_reg) > QUEUE_DEPTH)
            sz = CW'(QUEUE_DEPTH);
        else
            sz = CW'(qsize_reg);
        psz = (32'(psize_reg) > STACK_DEPTH) ? PW'(STACK_DEPTH) : PW'(psize_reg);
        col_act = (q_reg != '0) && (32'(q_reg) <= 7) && colen_reg[3'(32'(q_reg) - 1)];
    end

    logic [HW-1:0] tail_nx, head_nx;
    always_comb
    begin
        tail_nx = ((32'(tail_reg[q_reg]) + 1) >= 32'(sz)) ? '0 : HW'(32'(tail_reg[q_reg]) + 1);
        head_nx = ((32'(head_reg[q_reg]) + 1) >= 32'(sz)) ? '0 : HW'(32'(head_reg[q_reg]) + 1);
    end

    logic [QW-1:0] in_q;
    assign in_q = QW'(in_data.queue_sel);

    always_comb
    begin
        qra = QAW'(32'(in_q) * QUEUE_DEPTH + 32'(head_reg[in_q]));
        sra = SAW'(32'(q_reg) * STACK_DEPTH + 32'(di_reg) - 1);
        qwe = 1'b0;
        qwa = QAW'(32'(q_reg) * QUEUE_DEPTH + 32'(tail_reg[q_reg]));
        qwd = op_reg.event_in;
        swe = 1'b0;
        swa = SAW'(32'(q_reg) * STACK_DEPTH + 32'(scnt_reg[q_reg]));
        if (state_reg == S_EXEC && qvalid_reg && cnt_reg[q_reg] < sz &&
            (op_reg.kind == OP_ENQ || (op_reg.kind == OP_GATED_ENQ && col_act)))
            qwe = 1'b1;
        if (state_reg == S_DUMP_WR && cnt_reg[q_reg] < sz)
        begin
            qwe = 1'b1;
            qwd = srd;
        end
        if (state_reg == S_EXEC && qvalid_reg && op_reg.kind == OP_PUSH &&
            scnt_reg[q_reg] < psz)
            swe = 1'b1;
    end

    mqef_mem #(.DEPTH(NUM_QUEUES * QUEUE_DEPTH), .WIDTH(32)) u_qmem (
        .clk(clk), .we(qwe), .waddr(qwa), .wdata(qwd), .raddr(qra), .rdata(qrd));
    mqef_mem #(.DEPTH(NUM_QUEUES * STACK_DEPTH), .WIDTH(32)) u_smem (
        .clk(clk), .we(swe), .waddr(swa), .wdata(op_reg.event_in), .raddr(sra), .rdata(srd));

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            qsize_reg     <= 5'd16;
            psize_reg     <= 3'd4;
            colen_reg     <= 7'h7F;
            out_valid_reg <= 1'b0;
            qvalid_reg    <= 1'b0;
            q_reg         <= '0;
            di_reg        <= '0;
            st_reg        <= ST_OK;
            evo_reg       <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
                scnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_data.index)
                    REG_QUEUE_SIZE:    qsize_reg <= cfg_data.data[4:0];
                    REG_PUSH_SIZE:     psize_reg <= cfg_data.data[2:0];
                    REG_COLUMN_ENABLE: colen_reg <= cfg_data.data[6:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        op_reg     <= in_data;
                        q_reg      <= in_q;
                        qvalid_reg <= 32'(in_data.queue_sel) < NUM_QUEUES;
                        st_reg     <= ST_OK;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    evo_reg   <= (qvalid_reg && cnt_reg[q_reg] != '0 &&
                                  (op_reg.kind == OP_DEQ || op_reg.kind == OP_PEEK)) ?
                                 qrd : '0;
                    if (qvalid_reg)
                    begin
                        case (op_reg.kind)
                            OP_ENQ, OP_GATED_ENQ:
                            begin
                                if (op_reg.kind == OP_GATED_ENQ && !col_act)
                                    st_reg <= ST_DROPPED;
                                else if (cnt_reg[q_reg] >= sz)
                                    st_reg <= ST_FULL;
                                else
                                begin
                                    cnt_reg[q_reg]  <= cnt_reg[q_reg] + 1'b1;
                                    tail_reg[q_reg] <= tail_nx;
                                end
                            end
                            OP_DEQ, OP_PEEK:
                            begin
                                if (cnt_reg[q_reg] == '0)
                                    st_reg <= ST_EMPTY;
                                else if (op_reg.kind == OP_DEQ)
                                begin
                                    cnt_reg[q_reg]  <= cnt_reg[q_reg] - 1'b1;
                                    head_reg[q_reg] <= head_nx;
                                end
                            end
                            OP_PUSH:
                            begin
                                if (scnt_reg[q_reg] < psz)
                                    scnt_reg[q_reg] <= scnt_reg[q_reg] + 1'b1;
                                else
                                    st_reg <= ST_STK_FULL;
                            end
                            OP_DUMP:
                            begin
                                if (!col_act)
                                begin
                                    if (scnt_reg[q_reg] != '0)
                                        st_reg <= ST_DROPPED;
                                    scnt_reg[q_reg] <= '0;
                                end
                                else if (scnt_reg[q_reg] != '0)
                                begin
                                    di_reg    <= scnt_reg[q_reg];
                                    state_reg <= S_DUMP_RD;
                                end
                            end
                            OP_RST_Q:
                            begin
                                head_reg[q_reg] <= '0;
                                tail_reg[q_reg] <= '0;
                                cnt_reg[q_reg]  <= '0;
                                scnt_reg[q_reg] <= '0;
                            end
                            default:
                            begin
                                for (int i = 0; i < NUM_QUEUES; i++)
                                begin
                                    head_reg[i] <= '0;
                                    tail_reg[i] <= '0;
                                    cnt_reg[i]  <= '0;
                                    scnt_reg[i] <= '0;
                                end
                            end
                        endcase
                    end
                end
                S_DUMP_RD:
                begin
                    state_reg <= S_DUMP_WR;
                end
                S_DUMP_WR:
                begin
                    if (cnt_reg[q_reg] >= sz)
                        st_reg <= ST_FULL;
                    else
                    begin
                        cnt_reg[q_reg]  <= cnt_reg[q_reg] + 1'b1;
                        tail_reg[q_reg] <= tail_nx;
                    end
                    di_reg <= di_reg - 1'b1;
                    if (di_reg == PW'(1))
                    begin
                        scnt_reg[q_reg] <= '0;
                        state_reg       <= S_DONE;
                    end
                    else
                        state_reg <= S_DUMP_RD;
                end
                S_DONE:
                begin
                    // wait here while the previous result is still unclaimed
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (qvalid_reg)
                        begin
                            out_reg.status     <= st_reg;
                            out_reg.event_out  <= evo_reg;
                            out_reg.count      <= 5'(cnt_reg[q_reg]);
                            out_reg.empty_flag <= cnt_reg[q_reg] == '0;
                            out_reg.full_flag  <= cnt_reg[q_reg] >= sz;
                        end
                        else
                        begin
                            out_reg.status     <= ST_EMPTY;
                            out_reg.event_out  <= '0;
                            out_reg.count      <= '0;
                            out_reg.empty_flag <= 1'b1;
                            out_reg.full_flag  <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/core/mqef_mem.sv =====
// Synchronous single-port-write, single-read memory with registered read data.
module mqef_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== tb/multi_queue_event_fifo_core_checker.sv =====
// Checker for the multi-queue event FIFO core: channel monitor, predictor and scoreboard.
module multi_queue_event_fifo_core_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  mqef_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  mqef_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  mqef_pkg::cfg_item_t cfg_data,
    output int                  fail_count,
    output int                  pending
);
    import mqef_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ = NUM_QUEUES_DEF;
    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int SD = STACK_DEPTH_DEF;

    logic [4:0]  qsize_reg;
    logic [2:0]  psize_reg;
    logic [6:0]  col_en_reg;

    logic [31:0] ev_mem [NQ][QD];
    logic [31:0] stk_mem [NQ][SD];
    logic [3:0]  head_idx [NQ];
    logic [3:0]  tail_idx [NQ];
    logic [4:0]  q_count [NQ];
    logic [2:0]  stk_count [NQ];

    out_item_t   expected_results [$];

    function automatic logic [4:0] used_qsize();
        if (qsize_reg == 0)
            return 5'd1;
        if (qsize_reg > QD)
            return 5'(QD);
        return qsize_reg;
    endfunction

    function automatic logic [2:0] used_psize();
        return (psize_reg > SD) ? 3'(SD) : psize_reg;
    endfunction

    function automatic logic col_active(logic [2:0] q);
        return (q != 0) && col_en_reg[q - 1];
    endfunction

    function automatic void clear_q(int q);
        head_idx[q]  = '0;
        tail_idx[q]  = '0;
        q_count[q]   = '0;
        stk_count[q] = '0;
    endfunction

    function automatic logic [2:0] store_event(logic [2:0] q, logic [31:0] ev);
        logic [4:0] sz;
        logic [4:0] t;
        sz = used_qsize();
        if (q_count[q] >= sz)
            return ST_FULL;
        ev_mem[q][tail_idx[q]] = ev;
        q_count[q] = q_count[q] + 1;
        t = {1'b0, tail_idx[q]} + 5'd1;
        tail_idx[q] = (t >= sz) ? 4'd0 : t[3:0];
        return ST_OK;
    endfunction

    function automatic out_item_t apply_op(in_item_t it);
        out_item_t  r;
        logic [2:0] q;
        logic [4:0] sz;
        logic [4:0] h;
        int         i;
        q = it.queue_sel;
        sz = used_qsize();
        r.status = ST_OK;
        r.event_out = '0;
        case (it.kind)
            OP_ENQ:
                r.status = store_event(q, it.event_in);
            OP_GATED_ENQ:
                r.status = col_active(q) ? store_event(q, it.event_in) : ST_DROPPED;
            OP_DEQ, OP_PEEK:
            begin
                if (q_count[q] == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.event_out = ev_mem[q][head_idx[q]];
                    if (it.kind == OP_DEQ)
                    begin
                        q_count[q] = q_count[q] - 1;
                        h = {1'b0, head_idx[q]} + 5'd1;
                        head_idx[q] = (h >= sz) ? 4'd0 : h[3:0];
                    end
                end
            end
            OP_PUSH:
            begin
                if (stk_count[q] < used_psize() && stk_count[q] < SD)
                begin
                    stk_mem[q][stk_count[q]] = it.event_in;
                    stk_count[q] = stk_count[q] + 1;
                end
                else
                    r.status = ST_STK_FULL;
            end
            OP_DUMP:
            begin
                if (!col_active(q))
                begin
                    if (stk_count[q] != 0)
                        r.status = ST_DROPPED;
                end
                else
                begin
                    for (i = int'(stk_count[q]) - 1; i >= 0; i--)
                        if (store_event(q, stk_mem[q][i]) != ST_OK)
                            r.status = ST_FULL;
                end
                stk_count[q] = '0;
            end
            OP_RST_Q:
                clear_q(q);
            default:
                for (i = 0; i < NQ; i++)
                    clear_q(i);
        endcase
        r.count = q_count[q];
        r.empty_flag = (q_count[q] == 0);
        r.full_flag = (q_count[q] >= sz);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            qsize_reg = 5'd16;
            psize_reg = 3'd4;
            col_en_reg = 7'h7f;
            for (int q = 0; q < NQ; q++)
                clear_q(q);
            expected_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_data.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.event_out !== e.event_out)
                    begin
                        $error("event_out: expected %h, got %h", e.event_out,
                               out_data.event_out);
                        fail_count++;
                    end
                    if (out_data.count !== e.count)
                    begin
                        $error("count: expected %0d, got %0d", e.count, out_data.count);
                        fail_count++;
                    end
                    if (out_data.empty_flag !== e.empty_flag)
                    begin
                        $error("empty_flag: expected %b, got %b", e.empty_flag,
                               out_data.empty_flag);
                        fail_count++;
                    end
                    if (out_data.full_flag !== e.full_flag)
                    begin
                        $error("full_flag: expected %b, got %b", e.full_flag,
                               out_data.full_flag);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_data.index)
                    REG_QUEUE_SIZE:    qsize_reg = cfg_data.data[4:0];
                    REG_PUSH_SIZE:     psize_reg = cfg_data.data[2:0];
                    REG_COLUMN_ENABLE: col_en_reg = cfg_data.data[6:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_op(in_data));
            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/multi_queue_event_fifo_core_tb.sv =====
// Testbench top for the multi-queue event FIFO core: stimulus, flow control and verdict.
module multi_queue_event_fifo_core_tb;
    import mqef_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 16;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    cfg_item_t cfg_data = '0;
    int        fail_count;
    int        pending;
    int        cycles = 0;
    bit        stall_on = 1'b0;
    bit        long_hold = 1'b0;

    always #5 clk = ~clk;

    multi_queue_event_fifo_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    multi_queue_event_fifo_core_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("multi_queue_event_fifo_core verification failed");
            $finish;
        end
    end

    // result side flow control
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_op(logic [2:0] kind, logic [2:0] q, logic [31:0] ev);
        in_data <= '{kind: kind, queue_sel: q, event_in: ev};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (stall_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_data <= '{index: idx, data: val};
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_op();
        int          pick;
        logic [2:0]  kind;
        pick = $urandom_range(0, 99);
        if (pick < 22)
            kind = OP_ENQ;
        else if (pick < 36)
            kind = OP_GATED_ENQ;
        else if (pick < 56)
            kind = OP_DEQ;
        else if (pick < 66)
            kind = OP_PEEK;
        else if (pick < 82)
            kind = OP_PUSH;
        else if (pick < 92)
            kind = OP_DUMP;
        else if (pick < 97)
            kind = OP_RST_Q;
        else
            kind = OP_RST_ALL;
        send_op(kind, 3'($urandom_range(0, 7)), $urandom());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every event queue word once so no later queue read hits unwritten memory
        for (int q = 0; q < NUM_QUEUES_DEF; q++)
            for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
                send_op(OP_ENQ, 3'(q), $urandom());
        send_op(OP_RST_ALL, 3'd0, '0);
        drain();

        send_op(OP_ENQ, 3'd1, 32'hffff_ffff);
        send_op(OP_ENQ, 3'd1, 32'h0000_0000);
        send_op(OP_PEEK, 3'd1, '0);
        send_op(OP_DEQ, 3'd1, '0);
        send_op(OP_DEQ, 3'd1, '0);
        send_op(OP_DEQ, 3'd1, '0);
        send_op(OP_GATED_ENQ, 3'd0, 32'h1234_5678);
        send_op(OP_PUSH, 3'd0, 32'haaaa_5555);
        send_op(OP_DUMP, 3'd0, '0);
        for (int i = 0; i < 5; i++)
            send_op(OP_PUSH, 3'd2, 32'h100 + i);
        send_op(OP_DUMP, 3'd2, '0);
        send_op(OP_PEEK, 3'd2, '0);
        send_op(OP_RST_Q, 3'd2, '0);
        send_op(OP_ENQ, 3'd3, 32'h5555_aaaa);
        send_op(OP_RST_ALL, 3'd3, '0);
        drain();
        write_reg(REG_QUEUE_SIZE, 32'd1);
        write_reg(REG_COLUMN_ENABLE, 32'h0);
        send_op(OP_ENQ, 3'd4, 32'h1);
        send_op(OP_ENQ, 3'd4, 32'h2);
        send_op(OP_GATED_ENQ, 3'd5, 32'h3);
        send_op(OP_PUSH, 3'd5, 32'h4);
        send_op(OP_DUMP, 3'd5, '0);
        drain();

        stall_on = 1'b1;
        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_QUEUE_SIZE, 32'd16);
                    write_reg(REG_PUSH_SIZE, 32'd4);
                    write_reg(REG_COLUMN_ENABLE, 32'h7f);
                    long_hold = 1'b1;
                end
                1:
                begin
                    write_reg(REG_QUEUE_SIZE, 32'd0);
                    write_reg(REG_PUSH_SIZE, 32'd0);
                end
                2:
                begin
                    write_reg(REG_QUEUE_SIZE, 32'd31);
                    write_reg(REG_PUSH_SIZE, 32'd7);
                end
                default:
                begin
                    write_reg(REG_QUEUE_SIZE, $urandom_range(0, 31));
                    write_reg(REG_PUSH_SIZE, $urandom_range(0, 7));
                    write_reg(REG_COLUMN_ENABLE, $urandom_range(0, 127));
                end
            endcase
            if (phase == 8)
                stall_on = 1'b0;
            for (int n = 0; n < 105; n++)
                random_op();
            drain();
        end

        if (fail_count == 0)
            $display("multi_queue_event_fifo_core verification clean");
        else
            $display("multi_queue_event_fifo_core verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mqef_pkg.sv
rtl/core/mqef_mem.sv
rtl/core/multi_queue_event_fifo_core.sv
tb/multi_queue_event_fifo_core_checker.sv
tb/multi_queue_event_fifo_core_tb.sv
